@@ rtl/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// shared widths, token kind codes, character codes and byte classifiers
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int POS_W         = 32;
  localparam int LINE_W        = 32;
  localparam int KIND_W        = 6;
  localparam int TOK_LEN_W     = 16;
  localparam int MAX_TOKEN_LEN = 65535;
  // run length saturates one above the maximum
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 2);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t K_NONE     = 6'd0;
  localparam kind_t K_ERROR    = 6'd1;
  localparam kind_t K_VARIABLE = 6'd2;
  localparam kind_t K_ARGS     = 6'd3;
  localparam kind_t K_NUMBER   = 6'd4;
  localparam kind_t K_STRING   = 6'd5;
  localparam kind_t K_BUILTIN0 = 6'd6;
  localparam kind_t K_OP0      = 6'd22;
  localparam kind_t K_OP_LAST  = 6'd40;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // one result item
  typedef struct packed {
    kind_t                token_kind;
    logic [POS_W-1:0]     token_start;
    logic [TOK_LEN_W-1:0] token_length;
    logic [LINE_W-1:0]    line_count;
    logic                 last_of_run;
  } result_t;

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // skipped characters other than newline
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_COLON) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_LBRACE) || (b == CH_RBRACE) ||
           (b == CH_CR) || (b == CH_TAB);
  endfunction

  // builtin kind from its first letter, error for an unknown letter
  function automatic kind_t builtin_kind_of(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h41:   k = K_BUILTIN0 + 6'd0;   // A
      8'h42:   k = K_BUILTIN0 + 6'd1;   // B
      8'h43:   k = K_BUILTIN0 + 6'd2;   // C
      8'h44:   k = K_BUILTIN0 + 6'd3;   // D
      8'h46:   k = K_BUILTIN0 + 6'd4;   // F
      8'h47:   k = K_BUILTIN0 + 6'd5;   // G
      8'h49:   k = K_BUILTIN0 + 6'd6;   // I
      8'h4C:   k = K_BUILTIN0 + 6'd7;   // L
      8'h4E:   k = K_BUILTIN0 + 6'd8;   // N
      8'h4F:   k = K_BUILTIN0 + 6'd9;   // O
      8'h50:   k = K_BUILTIN0 + 6'd10;  // P
      8'h51:   k = K_BUILTIN0 + 6'd11;  // Q
      8'h52:   k = K_BUILTIN0 + 6'd12;  // R
      8'h53:   k = K_BUILTIN0 + 6'd13;  // S
      8'h54:   k = K_BUILTIN0 + 6'd14;  // T
      8'h57:   k = K_BUILTIN0 + 6'd15;  // W
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  // operator kind, none when the byte is no operator
  function automatic kind_t op_kind_of(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_AT:   k = K_OP0 + 6'd0;
      8'h21:   k = K_OP0 + 6'd1;   // !
      8'h7E:   k = K_OP0 + 6'd2;   // ~
      8'h2C:   k = K_OP0 + 6'd3;   // ,
      8'h5B:   k = K_OP0 + 6'd4;   // [
      8'h5D:   k = K_OP0 + 6'd5;   // ]
      8'h2B:   k = K_OP0 + 6'd6;   // +
      8'h2D:   k = K_OP0 + 6'd7;   // -
      8'h2A:   k = K_OP0 + 6'd8;   // *
      8'h2F:   k = K_OP0 + 6'd9;   // /
      8'h25:   k = K_OP0 + 6'd10;  // %
      8'h5E:   k = K_OP0 + 6'd11;  // ^
      8'h3E:   k = K_OP0 + 6'd12;  // >
      8'h3C:   k = K_OP0 + 6'd13;  // <
      8'h3F:   k = K_OP0 + 6'd14;  // ?
      8'h26:   k = K_OP0 + 6'd15;  // &
      8'h7C:   k = K_OP0 + 6'd16;  // |
      8'h3B:   k = K_OP0 + 6'd17;  // ;
      8'h3D:   k = K_OP0 + 6'd18;  // =
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/stl_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_in_if
// source channel: one byte or an end-of-source marker per transfer
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] source_byte;

  modport source (output valid, output mode, output source_byte, input ready);
  modport sink   (input valid, input mode, input source_byte, output ready);
endinterface

@@ rtl/stl_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_out_if
// token channel: one token per transfer
// ----------------------------------------------------------------------------
interface stl_out_if;
  import stl_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_t                token_kind;
  logic [POS_W-1:0]     token_start;
  logic [TOK_LEN_W-1:0] token_length;
  logic [LINE_W-1:0]    line_count;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output line_count, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input line_count, input last_of_run,
                  output ready);
endinterface

@@ rtl/script_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer
// streaming tokenizer: bytes in, tokens with offset, length, kind and lines out
// ----------------------------------------------------------------------------
// output: a token is offered once the transfer that completes it has written it
//   into the token queue and every earlier token has been taken
// throughput: one input transfer per cycle while the four-entry token queue
//   has room for the two tokens that one input may yield
// reset: synchronous active-low rst_n returns the scanner to idle at offset
//   zero and empties the queue; the queue entries themselves are not cleared
// ----------------------------------------------------------------------------
module script_token_lexer (
  input  logic          clk,
  input  logic          rst_n,
  stl_in_if.sink        in_chan,
  stl_out_if.source     out_chan
);
  import stl_pkg::*;

  // one-hot scanner state
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_COMMENT = 6'b000010,
    ST_IDENT   = 6'b000100,
    ST_BUILTIN = 6'b001000,
    ST_NUMBER  = 6'b010000,
    ST_STRING  = 6'b100000
  } scan_state_t;

  // scanner state
  scan_state_t       state_r,  state_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;     // offset of the next byte
  logic [POS_W-1:0]  start_r,  start_nxt;   // start of the open token
  logic [LEN_W-1:0]  len_r,    len_nxt;     // saturating run length
  kind_t             bkind_r,  bkind_nxt;   // builtin kind from first letter
  logic              delim_r,  delim_nxt;   // string closes on '"' when set
  logic              under_r,  under_nxt;   // identifier began with '_'
  logic [LINE_W-1:0] lines_r,  lines_nxt;   // newlines skipped so far

  // token queue
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   head_r, tail_r;
  logic [FIFO_AW:0]     count_r;

  logic       in_fire;
  logic       out_fire;
  logic [7:0] b;
  logic       eos;
  logic       pend_emit;    // open token closes on this transfer
  logic       idle_run;     // byte is handled as from idle
  logic       idle_put;     // idle handling yields an operator or error token
  kind_t      idle_kind;
  kind_t      pend_kind;
  result_t    pend_res;
  result_t    second_res;
  logic       second_v;
  result_t    res0, res1;
  logic       push0, push1;
  logic [LEN_W-1:0] len_grown;

  // builds a result, turning an over-long token into a one-byte error
  function automatic result_t make_res(input kind_t k, input logic [POS_W-1:0] s,
                                       input logic [LEN_W-1:0] l,
                                       input logic [LINE_W-1:0] nl);
    result_t r;
    r.token_kind  = k;
    r.token_start = s;
    r.line_count  = nl;
    r.last_of_run = 1'b0;
    if (l > LEN_W'(MAX_TOKEN_LEN)) begin
      r.token_kind   = K_ERROR;
      r.token_length = TOK_LEN_W'(1);
    end else begin
      r.token_length = l[TOK_LEN_W-1:0];
    end
    return r;
  endfunction

  // room for the two tokens one transfer may produce
  assign in_chan.ready = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_chan.valid && out_chan.ready;
  assign b             = in_chan.source_byte;

  // length stops one past the maximum so an over-long run stays flagged
  assign len_grown = (len_r <= LEN_W'(MAX_TOKEN_LEN)) ? len_r + 1'b1 : len_r;

  // kind of the open token
  always_comb begin
    unique case (state_r)
      ST_IDENT:   pend_kind = (under_r && (len_r == LEN_W'(1))) ? K_ARGS : K_VARIABLE;
      ST_BUILTIN: pend_kind = bkind_r;
      ST_NUMBER:  pend_kind = K_NUMBER;
      ST_STRING:  pend_kind = K_STRING;
      default:    pend_kind = K_NONE;
    endcase
  end

  // scanner next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    bkind_nxt = bkind_r;
    delim_nxt = delim_r;
    under_nxt = under_r;
    lines_nxt = lines_r;
    eos       = 1'b0;
    pend_emit = 1'b0;
    idle_run  = 1'b0;
    idle_put  = 1'b0;
    idle_kind = K_ERROR;

    if (in_fire) begin
      if (in_chan.mode) begin
        // end of source: flush the open token, then back to reset values
        eos       = 1'b1;
        pend_emit = (state_r != ST_IDLE) && (state_r != ST_COMMENT);
        state_nxt = ST_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        len_nxt   = '0;
        bkind_nxt = K_NONE;
        delim_nxt = 1'b0;
        under_nxt = 1'b0;
        lines_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        unique case (state_r)
          ST_COMMENT: begin
            if (b == CH_NL) begin
              lines_nxt = lines_r + 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          ST_STRING: begin
            if (b == (delim_r ? CH_DQUOTE : CH_SQUOTE)) begin
              pend_emit = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              len_nxt = len_grown;
            end
          end
          ST_IDENT: begin
            if (is_lower(b) || is_digit(b) || (b == CH_UNDERSCORE)) begin
              len_nxt = len_grown;
            end else begin
              pend_emit = 1'b1;
              idle_run  = 1'b1;
            end
          end
          ST_BUILTIN: begin
            if (is_upper(b) || (b == CH_UNDERSCORE)) begin
              len_nxt = len_grown;
            end else begin
              pend_emit = 1'b1;
              idle_run  = 1'b1;
            end
          end
          ST_NUMBER: begin
            if (is_digit(b)) begin
              len_nxt = len_grown;
            end else begin
              pend_emit = 1'b1;
              idle_run  = 1'b1;
            end
          end
          default: begin
            idle_run = 1'b1;
          end
        endcase

        // byte seen from idle, possibly right after closing a token
        if (idle_run) begin
          state_nxt = ST_IDLE;
          priority if (is_blank(b)) begin
            // skipped
          end else if (b == CH_NL) begin
            lines_nxt = lines_r + 1'b1;
          end else if (b == CH_HASH) begin
            state_nxt = ST_COMMENT;
          end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
            // string body starts after the quote
            state_nxt = ST_STRING;
            delim_nxt = (b == CH_DQUOTE);
            start_nxt = pos_r + 1'b1;
            len_nxt   = '0;
          end else if (is_lower(b) || (b == CH_UNDERSCORE)) begin
            state_nxt = ST_IDENT;
            start_nxt = pos_r;
            len_nxt   = LEN_W'(1);
            under_nxt = (b == CH_UNDERSCORE);
          end else if (is_upper(b)) begin
            state_nxt = ST_BUILTIN;
            start_nxt = pos_r;
            len_nxt   = LEN_W'(1);
            bkind_nxt = builtin_kind_of(b);
          end else if (is_digit(b)) begin
            state_nxt = ST_NUMBER;
            start_nxt = pos_r;
            len_nxt   = LEN_W'(1);
          end else begin
            // operator or stray byte, one-byte token at once
            idle_put  = 1'b1;
            idle_kind = (op_kind_of(b) != K_NONE) ? op_kind_of(b) : K_ERROR;
          end
        end
      end
    end
  end

  // up to two tokens per transfer: the closed token first, then the byte's own
  // token or the end-of-source marker
  always_comb begin
    pend_res   = make_res(pend_kind, start_r, len_r, lines_r);
    second_v   = eos || idle_put;
    second_res = eos ? make_res(K_NONE, pos_r, '0, lines_r)
                     : make_res(idle_kind, pos_r, LEN_W'(1), lines_r);
    second_res.last_of_run = 1'b1;
    if (pend_emit) begin
      res0  = pend_res;
      res1  = second_res;
      push0 = 1'b1;
      push1 = second_v;
    end else begin
      res0  = second_res;
      res1  = second_res;
      push0 = second_v;
      push1 = 1'b0;
    end
    res0.last_of_run = !push1;
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      bkind_r <= K_NONE;
      delim_r <= 1'b0;
      under_r <= 1'b0;
      lines_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      bkind_r <= bkind_nxt;
      delim_r <= delim_nxt;
      under_r <= under_nxt;
      lines_r <= lines_nxt;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (out_fire) begin
        head_r <= head_r + 1'b1;
      end
      tail_r  <= tail_r + FIFO_AW'(push0) + FIFO_AW'(push1);
      count_r <= count_r + (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1)
                 - (FIFO_AW+1)'(out_fire);
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[tail_r] <= res0;
    end
    if (push1) begin
      fifo_r[tail_r + 1'b1] <= res1;
    end
  end

  assign out_chan.valid        = (count_r != '0);
  assign out_chan.token_kind   = fifo_r[head_r].token_kind;
  assign out_chan.token_start  = fifo_r[head_r].token_start;
  assign out_chan.token_length = fifo_r[head_r].token_length;
  assign out_chan.line_count   = fifo_r[head_r].line_count;
  assign out_chan.last_of_run  = fifo_r[head_r].last_of_run;

endmodule

@@ rtl/stl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_checker
// port-level checks on the token stream, bound to the tokenizer
// ----------------------------------------------------------------------------
module stl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input stl_pkg::kind_t                 out_kind,
  input logic [stl_pkg::TOK_LEN_W-1:0]  out_length,
  input logic                           out_last
);
  import stl_pkg::*;

  // nothing offered right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token offered straight after reset");

  // end-of-source marker is empty and closes its run
  a_none_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == K_NONE)) |-> (out_last && (out_length == '0)))
    else $error("end-of-source token malformed");

  // operators are single bytes and kinds stay in range
  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind >= K_OP0)) |-> ((out_kind <= K_OP_LAST) && (out_length == 16'd1)))
    else $error("operator token malformed");

  // a stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_length)))
    else $error("stalled token changed");

endmodule

bind script_token_lexer stl_checker u_stl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_kind   (out_chan.token_kind),
  .out_length (out_chan.token_length),
  .out_last   (out_chan.last_of_run)
);
